// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the ordered list RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, masked while reset is high.
`define OLAD_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked property, checked during reset as well.
`define OLAD_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/core/olad_pkg.sv =====
// Package for the ordered list block: field widths, operation and status
// codes, controller states and the controller/datapath interface structs.
`timescale 1ns / 1ps
`default_nettype none

package olad_pkg;

  localparam int DEF_CAPACITY = 32;
  localparam int DEF_ID_BITS  = 16;

  localparam int KIND_W   = 2;
  localparam int ID_W     = 16;
  localparam int POS_W    = 8;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 6;

  localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DUMP   = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd3;

  typedef enum logic {
    S_IDLE,
    S_DUMP
  } olad_state_t;

  typedef struct packed {
    logic accept;     // item taken this cycle
    logic dump_step;  // emit the next dump entry
  } olad_cmd_t;

  typedef struct packed {
    logic out_free;   // output register can load this cycle
    logic dump_last;  // current dump entry is the final one
    logic list_empty; // no entries held
  } olad_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/olad_if.sv =====
// Valid/ready channel interfaces for the ordered list block.
// Depends on olad_pkg for the payload widths.
`timescale 1ns / 1ps
`default_nettype none

interface olad_cmd_if;
  logic                        valid;
  logic                        ready;
  logic [olad_pkg::KIND_W-1:0] kind;
  logic [olad_pkg::ID_W-1:0]   package_id;
  logic [olad_pkg::POS_W-1:0]  position;

  modport source (output valid, kind, package_id, position, input ready);
  modport sink   (input valid, kind, package_id, position, output ready);
endinterface

interface olad_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [olad_pkg::STATUS_W-1:0] status;
  logic [olad_pkg::ID_W-1:0]     entry_value;
  logic [olad_pkg::COUNT_W-1:0]  entry_count;
  logic                          last;

  modport source (output valid, status, entry_value, entry_count, last, input ready);
  modport sink   (input valid, status, entry_value, entry_count, last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/olad_ctrl.sv =====
// Controller for the ordered list: idle/dump state machine, input handshake.
// Depends on olad_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module olad_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  input  wire logic [olad_pkg::KIND_W-1:0] kind,
  output logic                             in_ready,
  input  wire olad_pkg::olad_stat_t        stat,
  output olad_pkg::olad_cmd_t              cmd
);
  import olad_pkg::*;

  olad_state_t state;
  olad_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.accept && kind == KIND_DUMP && !stat.list_empty) begin
          state_next = S_DUMP;
        end
      end
      S_DUMP: begin
        if (stat.out_free && stat.dump_last) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd.accept    = 1'b0;
    cmd.dump_step = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready   = stat.out_free;
        cmd.accept = in_valid && stat.out_free;
      end
      S_DUMP: begin
        cmd.dump_step = stat.out_free;
      end
      default: ;
    endcase
  end

  `OLAD_ASSERT(a_single_result_stays_idle, clk, rst, (cmd.accept && kind != KIND_DUMP) |=> (state == S_IDLE), "non-dump item left the idle state")
  `OLAD_ASSERT(a_dump_entered_by_item, clk, rst, $rose(state == S_DUMP) |-> $past(cmd.accept), "dump started without an accepted item")

endmodule

`default_nettype wire

// ===== rtl/core/olad_dpath.sv =====
// Datapath for the ordered list: shifting entry cells, entry count, dump
// index and the output register. Depends on olad_pkg, olad_if, assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module olad_dpath #(
  parameter int CAPACITY = olad_pkg::DEF_CAPACITY,
  parameter int ID_BITS  = olad_pkg::DEF_ID_BITS
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire olad_pkg::olad_cmd_t         cmd,
  input  wire logic [olad_pkg::KIND_W-1:0] kind,
  input  wire logic [olad_pkg::ID_W-1:0]   package_id,
  input  wire logic [olad_pkg::POS_W-1:0]  position,
  output olad_pkg::olad_stat_t             stat,
  olad_rsp_if.source                       rsp
);
  import olad_pkg::*;

  localparam int SW   = (ID_BITS < ID_W) ? ID_BITS : ID_W;
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int IW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;
  localparam int CXW  = (CW > COUNT_W) ? CW : COUNT_W;

  logic [SW-1:0]       slots [CAPACITY];
  logic [CW-1:0]       total;
  logic [CW-1:0]       total_next;
  logic [IW-1:0]       idx;
  logic                out_valid;

  logic                is_full;
  logic                pos_bad;
  logic                app_ok;
  logic                del_ok;
  logic                dump_go;
  logic [CMPW-1:0]     pos_ext;
  logic [STATUS_W-1:0] op_status;
  logic [ID_W-1:0]     rd_value;
  logic [CXW-1:0]      cnt_op_ext;
  logic [CXW-1:0]      cnt_cur_ext;

  assign is_full = (total == CW'(CAPACITY));
  assign pos_ext = CMPW'(position);
  assign pos_bad = (position == '0) || (pos_ext > CMPW'(total));
  assign app_ok  = cmd.accept && (kind == KIND_APPEND) && !is_full;
  assign del_ok  = cmd.accept && (kind == KIND_DELETE) && !pos_bad;
  assign dump_go = cmd.accept && (kind == KIND_DUMP) && (total != '0);

  always_comb begin
    total_next = total;
    if (app_ok) begin
      total_next = total + CW'(1);
    end else if (del_ok) begin
      total_next = total - CW'(1);
    end
  end

  always_comb begin
    case (kind)
      KIND_APPEND: op_status = is_full ? STATUS_FULL : STATUS_OK;
      KIND_DELETE: op_status = pos_bad ? STATUS_RANGE : STATUS_OK;
      KIND_DUMP:   op_status = STATUS_EMPTY;
      default:     op_status = STATUS_OK;
    endcase
  end

  // Cells: append writes at the tail, delete pulls later cells down by one.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    if (g < CAPACITY - 1) begin : g_mid
      always_ff @(posedge clk) begin
        if (app_ok && total == CW'(g)) begin
          slots[g] <= package_id[SW-1:0];
        end else if (del_ok && CMPW'(g + 1) >= pos_ext) begin
          slots[g] <= slots[g+1];
        end
      end
    end else begin : g_end
      always_ff @(posedge clk) begin
        if (app_ok && total == CW'(g)) begin
          slots[g] <= package_id[SW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
    end else begin
      total <= total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      idx <= '0;
    end else if (cmd.dump_step) begin
      idx <= idx + IW'(1);
    end
  end

  always_comb begin
    rd_value         = '0;
    rd_value[SW-1:0] = slots[idx];
  end

  assign cnt_op_ext  = CXW'(total_next);
  assign cnt_cur_ext = CXW'(total);

  assign stat.out_free   = !out_valid || rsp.ready;
  assign stat.dump_last  = (CW'(idx) + CW'(1)) == total;
  assign stat.list_empty = (total == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((cmd.accept && !dump_go) || cmd.dump_step) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && !dump_go) begin
      rsp.status      <= op_status;
      rsp.entry_value <= '0;
      rsp.entry_count <= cnt_op_ext[COUNT_W-1:0];
      rsp.last        <= 1'b1;
    end else if (cmd.dump_step) begin
      rsp.status      <= STATUS_OK;
      rsp.entry_value <= rd_value;
      rsp.entry_count <= cnt_cur_ext[COUNT_W-1:0];
      rsp.last        <= stat.dump_last;
    end
  end

  assign rsp.valid = out_valid;

  `OLAD_ASSERT_ALWAYS(a_count_bound, clk, rst || (total <= CW'(CAPACITY)), "entry count above capacity")
  `OLAD_ASSERT(a_dump_last_marked, clk, rst, (cmd.dump_step && stat.dump_last) |=> (rsp.valid && rsp.last), "final dump entry not marked last")

endmodule

`default_nettype wire

// ===== rtl/core/ordered_list_append_delete.sv =====
// Ordered list of identifiers: tail append, delete at position, dump.
// Channels: cmd (sink) takes items {kind, package_id, position}; rsp
// (source) gives results {status, entry_value, entry_count, last}.
// Append and delete update the shifting cells in the cycle the item is
// taken; their single result shows on rsp in the next cycle.
// A dump of N entries gives N results, one per cycle while rsp is taken,
// the first once the controller has entered the dump state, later than an
// append result shows; an empty dump gives one result, in the next cycle.
// Appends, deletes and empty dumps can follow back to back; a dump takes no
// new item until its last entry is loaded, as the entries are read one at a
// time through the single cell read port walked by the dump index.
// The output register frees in the same cycle it is taken, so a new item
// is accepted while the previous result is being handed off.
// A stalled rsp holds its result and stops the dump walk; cmd.ready drops.
// Reset (rst, synchronous) empties the list and clears the output valid.
// Depends on olad_pkg, olad_if, olad_ctrl, olad_dpath.
`timescale 1ns / 1ps
`default_nettype none

module ordered_list_append_delete #(
  parameter int CAPACITY = olad_pkg::DEF_CAPACITY,
  parameter int ID_BITS  = olad_pkg::DEF_ID_BITS
) (
  input wire logic  clk,
  input wire logic  rst,
  olad_cmd_if.sink  cmd,
  olad_rsp_if.source rsp
);
  import olad_pkg::*;

  olad_cmd_t  ctl_cmd;
  olad_stat_t dp_stat;
  logic       in_ready;

  // Controller: decides when an item is taken and steps a dump.
  olad_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cmd.valid),
    .kind     (cmd.kind),
    .in_ready (in_ready),
    .stat     (dp_stat),
    .cmd      (ctl_cmd)
  );

  // Datapath: holds the entries and drives the result register.
  olad_dpath #(
    .CAPACITY (CAPACITY),
    .ID_BITS  (ID_BITS)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (ctl_cmd),
    .kind       (cmd.kind),
    .package_id (cmd.package_id),
    .position   (cmd.position),
    .stat       (dp_stat),
    .rsp        (rsp)
  );

  assign cmd.ready = in_ready;

endmodule

`default_nettype wire

// ===== tb/tb_ordered_list_append_delete.sv =====
// Self-checking testbench for ordered_list_append_delete: appends, deletes and dumps with
// random content and random stalls on both channels, all checked against a shadow list.
// Depends on olad_pkg, the olad_cmd_if/olad_rsp_if interfaces and the block itself.
`timescale 1ns / 1ps

module tb_ordered_list_append_delete;
  import olad_pkg::*;

  localparam int CAPACITY = DEF_CAPACITY;
  localparam int ID_BITS  = DEF_ID_BITS;

  // Kind value that the block ignores; it still answers with one plain result.
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  // Mask for the low ID_BITS of an identifier, the part that the list stores.
  localparam logic [ID_W-1:0] ID_KEEP =
    (ID_BITS >= ID_W) ? {ID_W{1'b1}} : ID_W'((64'd1 << ID_BITS) - 1);

  localparam int RANDOM_ITEMS   = 400;
  localparam int TAIL_ITEMS     = 60;    // last items go out with no idling
  localparam int HOLD_AT        = 150;   // accepted items before the long receiver hold
  localparam int LONG_HOLD      = 80;    // cycles of the long receiver hold
  localparam int DRAIN_CYCLES   = 10;
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake on either side
  localparam int SHOW_LIMIT     = 10;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   package_id;
    logic [POS_W-1:0]  position;
  } list_op_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     entry_value;
    logic [COUNT_W-1:0]  entry_count;
    logic                last;
  } list_reply_t;

  logic clk = 1'b0;
  logic rst;

  olad_cmd_if cmd ();
  olad_rsp_if rsp ();

  ordered_list_append_delete #(
    .CAPACITY(CAPACITY),
    .ID_BITS (ID_BITS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .rsp(rsp)
  );

  // 10 ns clock: low half first, so the first rising edge comes at 5 ns.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Items still to offer, and the replies that the shadow list says must come back.
  list_op_t    ops_to_send[$];
  list_reply_t replies_due[$];

  // Shadow copy of the list.
  logic [ID_W-1:0] list_ids[CAPACITY];
  int unsigned     list_len = 0;

  // Occupancy as the stimulus generator sees it; only steers delete positions.
  int unsigned fill_est = 0;

  int  total_items     = 0;
  int  accepted_items  = 0;
  int  checked_results = 0;
  int  err_count       = 0;
  int  dump_count      = 0;
  int  full_drops      = 0;
  int  range_rejects   = 0;
  int  empty_dumps     = 0;
  bit  cmd_took        = 1'b0;
  int  send_gap        = 0;
  int  stall_left      = 0;
  int  hold_left       = 0;
  bit  hold_done       = 1'b0;
  int  quiet_cycles    = 0;

  function automatic bit calm_tail();
    return ops_to_send.size() < TAIL_ITEMS;
  endfunction

  // Queue an item for the driver and track how full the list will be.
  task automatic add_op(input logic [KIND_W-1:0] op, input logic [ID_W-1:0] id,
                        input logic [POS_W-1:0] pos);
    list_op_t item;
    item.kind       = op;
    item.package_id = id;
    item.position   = pos;
    ops_to_send.push_back(item);
    total_items++;
    if (op == KIND_APPEND && fill_est < CAPACITY) fill_est++;
    if (op == KIND_DELETE && pos != 0 && pos <= fill_est) fill_est--;
  endtask

  task automatic push_reply(input logic [STATUS_W-1:0] st, input logic [ID_W-1:0] value,
                            input logic fin);
    list_reply_t r;
    r.status      = st;
    r.entry_value = value;
    r.entry_count = COUNT_W'(list_len);
    r.last        = fin;
    replies_due.push_back(r);
  endtask

  // Apply one accepted item to the shadow list and queue the replies it causes.
  task automatic apply_list_op(input logic [KIND_W-1:0] op, input logic [ID_W-1:0] id,
                               input logic [POS_W-1:0] pos);
    case (op)
      KIND_APPEND: begin
        if (list_len >= CAPACITY) begin
          full_drops++;
          push_reply(STATUS_FULL, '0, 1'b1);
        end else begin
          list_ids[list_len] = id & ID_KEEP;
          list_len++;
          push_reply(STATUS_OK, '0, 1'b1);
        end
      end
      KIND_DELETE: begin
        if (pos == 0 || pos > list_len) begin
          range_rejects++;
          push_reply(STATUS_RANGE, '0, 1'b1);
        end else begin
          // Close up the gap: every later entry moves down by one.
          for (int i = pos - 1; i + 1 < list_len; i++) list_ids[i] = list_ids[i + 1];
          list_len--;
          push_reply(STATUS_OK, '0, 1'b1);
        end
      end
      KIND_DUMP: begin
        dump_count++;
        if (list_len == 0) begin
          empty_dumps++;
          push_reply(STATUS_EMPTY, '0, 1'b1);
        end else begin
          for (int i = 0; i < list_len; i++)
            push_reply(STATUS_OK, list_ids[i], i + 1 == list_len);
        end
      end
      default: begin
        push_reply(STATUS_OK, '0, 1'b1);
      end
    endcase
  endtask

  // Driver: present the next item at the falling edge once the current one is taken.
  // Between items, drop valid for bursts of random length, except in quiet stretches
  // and in the tail of the run. Scramble the payload while valid is low.
  always @(negedge clk) begin
    list_op_t nxt;
    if (!rst && (!cmd.valid || cmd_took)) begin
      if (send_gap == 0 && !calm_tail() && ops_to_send.size() % 64 >= 16 &&
          $urandom_range(0, 5) == 0)
        send_gap = $urandom_range(1, 6);
      if (send_gap > 0 || ops_to_send.size() == 0) begin
        if (send_gap > 0) send_gap--;
        cmd.valid      <= 1'b0;
        cmd.kind       <= KIND_W'($urandom);
        cmd.package_id <= ID_W'($urandom);
        cmd.position   <= POS_W'($urandom);
      end else begin
        nxt = ops_to_send.pop_front();
        cmd.valid      <= 1'b1;
        cmd.kind       <= nxt.kind;
        cmd.package_id <= nxt.package_id;
        cmd.position   <= nxt.position;
      end
    end
  end

  // Receiver: hold ready low once for a long stretch so the block backs up and
  // drops cmd.ready while the driver keeps offering; otherwise stall in short bursts.
  always @(negedge clk) begin
    if (!rst) begin
      if (!hold_done && hold_left == 0 && accepted_items >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (stall_left == 0 && hold_left == 0 && !calm_tail() &&
          checked_results % 64 >= 16 && $urandom_range(0, 5) == 0)
        stall_left = $urandom_range(1, 6);
      if (hold_left > 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  // Monitor: at each rising edge, predict from the accepted item, then check the
  // accepted result against the oldest reply still due.
  always @(posedge clk) begin
    list_reply_t want;
    cmd_took = 1'b0;
    if (!rst) begin
      if (cmd.valid && cmd.ready) begin
        cmd_took = 1'b1;
        accepted_items++;
        apply_list_op(cmd.kind, cmd.package_id, cmd.position);
      end
      if (rsp.valid && rsp.ready) begin
        checked_results++;
        if (replies_due.size() == 0) begin
          err_count++;
          if (err_count <= SHOW_LIMIT)
            $display("[%0t] unexpected result: status=%0d value=%h count=%0d last=%0d",
                     $realtime, rsp.status, rsp.entry_value, rsp.entry_count, rsp.last);
        end else begin
          want = replies_due.pop_front();
          if (rsp.status !== want.status || rsp.entry_value !== want.entry_value ||
              rsp.entry_count !== want.entry_count || rsp.last !== want.last) begin
            err_count++;
            if (err_count <= SHOW_LIMIT) begin
              $display("[%0t] mismatch: expected status=%0d value=%h count=%0d last=%0d",
                       $realtime, want.status, want.entry_value, want.entry_count,
                       want.last);
              $display("[%0t]           got      status=%0d value=%h count=%0d last=%0d",
                       $realtime, rsp.status, rsp.entry_value, rsp.entry_count,
                       rsp.last);
            end
          end
        end
      end
    end
  end

  // Watchdog: end the run if neither channel moves for too long.
  always @(posedge clk) begin
    if (rst || (cmd.valid && cmd.ready) || (rsp.valid && rsp.ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("No handshake for %0d cycles; %0d replies still due",
               quiet_cycles, replies_due.size());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int                mode;
    int                seg_left;
    int                pick;
    int                app_pct;
    int                del_pct;
    int                dump_pct;
    int                n;
    logic [KIND_W-1:0] k;
    logic [POS_W-1:0]  p;

    rst            = 1'b1;
    cmd.valid      = 1'b0;
    cmd.kind       = '0;
    cmd.package_id = '0;
    cmd.position   = '0;
    rsp.ready      = 1'b0;

    // Directed part: empty-list cases, the ignored kind, identifier extremes,
    // deletes at head, tail, middle, zero and past the count, dumps of 0, 1 and more.
    add_op(KIND_DUMP,   16'h0000, 8'd0);
    add_op(KIND_DELETE, 16'h0000, 8'd1);
    add_op(KIND_DELETE, 16'hFFFF, 8'd0);
    add_op(KIND_UNUSED, 16'hFFFF, 8'hFF);
    add_op(KIND_APPEND, 16'h0000, 8'hFF);
    add_op(KIND_APPEND, 16'hFFFF, 8'h00);
    add_op(KIND_APPEND, 16'hA5A5, 8'h55);
    add_op(KIND_APPEND, 16'h5A5A, 8'hAA);
    add_op(KIND_DUMP,   16'hFFFF, 8'hFF);
    add_op(KIND_DELETE, 16'h1234, 8'd0);
    add_op(KIND_DELETE, 16'h1234, 8'd5);
    add_op(KIND_DELETE, 16'h1234, 8'd255);
    add_op(KIND_DELETE, 16'h0000, 8'd4);
    add_op(KIND_DELETE, 16'h0000, 8'd1);
    add_op(KIND_DUMP,   16'h0000, 8'd0);
    add_op(KIND_APPEND, 16'h8001, 8'd0);
    add_op(KIND_DELETE, 16'h0000, 8'd2);
    add_op(KIND_DUMP,   16'h0000, 8'd0);
    add_op(KIND_DELETE, 16'h0000, 8'd1);
    add_op(KIND_DELETE, 16'h0000, 8'd1);
    add_op(KIND_DUMP,   16'h0000, 8'd0);
    add_op(KIND_APPEND, 16'h1234, 8'd0);
    add_op(KIND_DUMP,   16'h0000, 8'd0);
    add_op(KIND_UNUSED, 16'h0000, 8'd0);

    // Random part in phases: grow (mostly appends, runs into the full list),
    // shrink (mostly valid deletes, drains to empty) and mixed. Open with a long
    // grow phase so the full list is reached early.
    seg_left = 0;
    mode     = 0;
    app_pct  = 0;
    del_pct  = 0;
    dump_pct = 0;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (seg_left == 0) begin
        mode     = (n == 0) ? 0 : $urandom_range(0, 2);
        seg_left = (n == 0) ? 60 : $urandom_range(15, 45);
        case (mode)
          0: begin app_pct = 75; del_pct = 12; dump_pct = 10; end
          1: begin app_pct = 15; del_pct = 72; dump_pct = 10; end
          default: begin app_pct = 40; del_pct = 42; dump_pct = 14; end
        endcase
      end
      seg_left--;
      pick = $urandom_range(0, 99);
      if (pick < app_pct) k = KIND_APPEND;
      else if (pick < app_pct + del_pct) k = KIND_DELETE;
      else if (pick < app_pct + del_pct + dump_pct) k = KIND_DUMP;
      else k = KIND_UNUSED;
      p = POS_W'($urandom_range(0, 255));
      if (k == KIND_DELETE) begin
        // Hit a live entry most of the time; otherwise zero, one past the end, or anything.
        pick = $urandom_range(0, 9);
        if (fill_est > 0 && pick < 8) p = POS_W'($urandom_range(1, fill_est));
        else if (pick == 8) p = '0;
        else if ($urandom_range(0, 1) == 0) p = POS_W'(fill_est + 1);
      end
      add_op(k, ID_W'($urandom), p);
    end

    // Hold reset, then release it on a falling edge.
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Wait for every item to be taken and every reply to arrive, then drain.
    while (accepted_items < total_items || replies_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d items and %0d results, %0d dumps (%0d on an empty list)",
             accepted_items, checked_results, dump_count, empty_dumps);
    $display("Appends dropped on a full list: %0d, deletes out of range: %0d, errors: %0d",
             full_drops, range_rejects, err_count);
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/olad_pkg.sv
rtl/core/olad_if.sv
rtl/core/olad_ctrl.sv
rtl/core/olad_dpath.sv
rtl/core/ordered_list_append_delete.sv
tb/tb_ordered_list_append_delete.sv
